[rtl/swarq_pkg.sv]
// ----------------------------------------------------------------------------
// Stop-and-wait sender package
// Types, codes and constants shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package swarq_pkg;

   localparam int SEQ_WIDTH       = 31;
   localparam int SUM_WIDTH       = 32;
   localparam int PAYLOAD_WIDTH   = 16;
   localparam int TICK_WIDTH      = 8;
   localparam int RESEND_WIDTH    = 8;
   localparam int DIVIDEND_WIDTH  = 32;
   localparam int DIV_COUNT_WIDTH = $clog2(DIVIDEND_WIDTH);
   localparam int SCALED_WIDTH    = SEQ_WIDTH + 4;
   localparam int PREFIX_BYTES    = 4;
   localparam int MIN_ACK_BYTES   = 5;

   localparam logic [PAYLOAD_WIDTH-1:0] PAYLOAD_RESET = 16'd800;
   localparam logic [TICK_WIDTH-1:0]    TIMEOUT_RESET = 8'd10;
   localparam logic [RESEND_WIDTH-1:0]  RESENDS_RESET = 8'd16;

   localparam logic [1:0] CSR_PKT_BYTES     = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT_TICKS = 2'd1;
   localparam logic [1:0] CSR_MAX_RESENDS   = 2'd2;

   typedef enum logic [1:0] {
      MODE_START,
      MODE_TICK,
      MODE_BYTE,
      MODE_NONE
   } mode_type;

   typedef enum logic [1:0] {
      ACTION_NONE,
      ACTION_SEND,
      ACTION_RESEND,
      ACTION_DONE
   } action_type;

   typedef enum logic [1:0] {
      PHASE_SPACE,
      PHASE_SIGN,
      PHASE_DIGITS,
      PHASE_DONE
   } phase_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_DIVIDE,
      STATE_FINISH
   } state_type;

   typedef struct packed {
      logic load_div;
      logic step_div;
      logic commit_start;
      logic commit_item;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } status_type;

   function automatic logic [7:0] prefix_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0: c = 8'h41;
         2'd1: c = 8'h43;
         2'd2: c = 8'h4B;
         default: c = 8'h20;
      endcase
      return c;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

endpackage

[rtl/swarq_ctrl.sv]
// ----------------------------------------------------------------------------
// Stop-and-wait sender controller
// Accepts words, sequences the packet count division and owns the result
// valid flag.
// ----------------------------------------------------------------------------
module swarq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_mode,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  swarq_pkg::status_type status,
   output swarq_pkg::cmd_type    cmd
);

   swarq_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic accept;
   logic is_start;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = (state_ff == swarq_pkg::STATE_IDLE) && req_valid && out_free;
   assign is_start = (swarq_pkg::mode_type'(req_mode) == swarq_pkg::MODE_START);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swarq_pkg::STATE_IDLE: begin
            if (accept && is_start) begin
               state_in = swarq_pkg::STATE_DIVIDE;
            end
         end
         swarq_pkg::STATE_DIVIDE: begin
            if (status.div_last) begin
               state_in = swarq_pkg::STATE_FINISH;
            end
         end
         swarq_pkg::STATE_FINISH: begin
            if (out_free) begin
               state_in = swarq_pkg::STATE_IDLE;
            end
         end
         default: begin
            state_in = swarq_pkg::STATE_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.load_div     = accept && is_start;
      cmd.commit_item  = accept && !is_start;
      cmd.step_div     = (state_ff == swarq_pkg::STATE_DIVIDE);
      cmd.commit_start = (state_ff == swarq_pkg::STATE_FINISH) && out_free;
      req_stall        = !((state_ff == swarq_pkg::STATE_IDLE) && out_free);
      if (cmd.commit_item || cmd.commit_start) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swarq_pkg::STATE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/swarq_dp.sv]
// ----------------------------------------------------------------------------
// Stop-and-wait sender datapath
// Packet count divider, transfer counters, timeout and ACK datagram parser.
// ----------------------------------------------------------------------------
module swarq_dp #(
   parameter int ACK_MAX_BYTES = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  swarq_pkg::cmd_type                     cmd,
   output swarq_pkg::status_type                  status,
   input  logic [1:0]                             req_mode,
   input  logic [swarq_pkg::SEQ_WIDTH-1:0]        req_file_length,
   input  logic [7:0]                             req_ack_byte,
   input  logic                                   req_ack_last,
   input  logic [swarq_pkg::PAYLOAD_WIDTH-1:0]    pkt_bytes,
   input  logic [swarq_pkg::TICK_WIDTH-1:0]       timeout_ticks,
   input  logic [swarq_pkg::RESEND_WIDTH-1:0]     max_resends,
   output logic [1:0]                             rsp_action,
   output logic                                   rsp_aborted,
   output logic [swarq_pkg::SEQ_WIDTH-1:0]        rsp_packet_seq,
   output logic [swarq_pkg::SEQ_WIDTH-1:0]        rsp_packet_total,
   output logic [swarq_pkg::SUM_WIDTH-1:0]        rsp_resent_total
);

   localparam int POS_WIDTH = $clog2(ACK_MAX_BYTES + 1);
   localparam int SW = swarq_pkg::SEQ_WIDTH;
   localparam int DW = swarq_pkg::DIVIDEND_WIDTH;
   localparam int PW = swarq_pkg::PAYLOAD_WIDTH;
   localparam int TW = swarq_pkg::TICK_WIDTH;
   localparam int RW = swarq_pkg::RESEND_WIDTH;
   localparam int UW = swarq_pkg::SUM_WIDTH;
   localparam int CW = swarq_pkg::DIV_COUNT_WIDTH;
   localparam int XW = swarq_pkg::SCALED_WIDTH;

   // Divider.
   logic [DW-1:0] div_quo_ff, div_quo_in;
   logic [PW-1:0] div_rem_ff, div_rem_in;
   logic [PW-1:0] div_divisor_ff, div_divisor_in;
   logic [CW-1:0] div_cnt_ff, div_cnt_in;
   logic [PW-1:0] divisor;
   logic [PW:0]   trial;
   logic          trial_fits;

   // Transfer state.
   logic          busy_ff, busy_in;
   logic [SW-1:0] seq_ff, seq_in;
   logic [SW-1:0] total_ff, total_in;
   logic [TW-1:0] wait_ff, wait_in;
   logic [RW-1:0] resend_cnt_ff, resend_cnt_in;
   logic [UW-1:0] sum_ff, sum_in;
   logic [1:0]    action_ff, action_in;
   logic          aborted_ff, aborted_in;

   // Parser state.
   logic [POS_WIDTH-1:0]  pos_ff, pos_in;
   logic                  prefix_ok_ff, prefix_ok_in;
   swarq_pkg::phase_type  phase_ff, phase_in;
   logic                  neg_ff, neg_in;
   logic [SW-1:0]         value_ff, value_in;
   logic                  ovf_ff, ovf_in;

   // Parser step results.
   logic [POS_WIDTH-1:0]  p_pos;
   logic                  p_prefix_ok;
   swarq_pkg::phase_type  p_phase;
   logic                  p_neg;
   logic [SW-1:0]         p_value;
   logic                  p_ovf;
   logic [3:0]            digit;
   logic [XW-1:0]         scaled;
   logic                  is_digit;

   logic [TW-1:0]         tick_limit;

   // Division by restoring steps, one quotient bit per cycle.
   assign divisor    = (pkt_bytes == '0) ? PW'(1) : pkt_bytes;
   assign trial      = {div_rem_ff, div_quo_ff[DW-1]};
   assign trial_fits = (trial >= {1'b0, div_divisor_ff});
   assign status.div_last = (div_cnt_ff == CW'(DW - 1));

   always_comb begin
      div_quo_in     = div_quo_ff;
      div_rem_in     = div_rem_ff;
      div_divisor_in = div_divisor_ff;
      div_cnt_in     = div_cnt_ff;
      if (cmd.load_div) begin
         div_quo_in     = {1'b0, req_file_length} + {{(DW-PW){1'b0}}, divisor} - DW'(1);
         div_rem_in     = '0;
         div_divisor_in = divisor;
         div_cnt_in     = '0;
      end else if (cmd.step_div) begin
         if (trial_fits) begin
            div_rem_in = PW'(trial - {1'b0, div_divisor_ff});
         end else begin
            div_rem_in = trial[PW-1:0];
         end
         div_quo_in = {div_quo_ff[DW-2:0], trial_fits};
         div_cnt_in = div_cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      div_quo_ff     <= div_quo_in;
      div_rem_ff     <= div_rem_in;
      div_divisor_ff <= div_divisor_in;
      div_cnt_ff     <= div_cnt_in;
   end

   // One byte of an ACK datagram.
   assign digit    = 4'(req_ack_byte - 8'h30);
   assign is_digit = (req_ack_byte >= 8'h30) && (req_ack_byte <= 8'h39);
   assign scaled   = ({{(XW-SW){1'b0}}, value_ff} << 3) + ({{(XW-SW){1'b0}}, value_ff} << 1)
                   + {{(XW-4){1'b0}}, digit};

   always_comb begin
      logic take_digit;
      take_digit  = 1'b0;
      p_pos       = pos_ff;
      p_prefix_ok = prefix_ok_ff;
      p_phase     = phase_ff;
      p_neg       = neg_ff;
      p_value     = value_ff;
      p_ovf       = ovf_ff;
      if ((pos_ff < POS_WIDTH'(ACK_MAX_BYTES)) && (phase_ff != swarq_pkg::PHASE_DONE)) begin
         p_pos = pos_ff + POS_WIDTH'(1);
         if (req_ack_byte == 8'h00) begin
            if (pos_ff <= POS_WIDTH'(swarq_pkg::PREFIX_BYTES)) begin
               p_prefix_ok = 1'b0;
            end
            p_phase = swarq_pkg::PHASE_DONE;
         end else if (pos_ff < POS_WIDTH'(swarq_pkg::PREFIX_BYTES)) begin
            if (req_ack_byte != swarq_pkg::prefix_char(pos_ff[1:0])) begin
               p_prefix_ok = 1'b0;
            end
         end else begin
            take_digit = 1'b1;
            if (phase_ff == swarq_pkg::PHASE_SPACE) begin
               if (swarq_pkg::is_space(req_ack_byte)) begin
                  take_digit = 1'b0;
               end else if ((req_ack_byte == 8'h2B) || (req_ack_byte == 8'h2D)) begin
                  p_neg      = (req_ack_byte == 8'h2D);
                  p_phase    = swarq_pkg::PHASE_SIGN;
                  take_digit = 1'b0;
               end else begin
                  p_phase = swarq_pkg::PHASE_DIGITS;
               end
            end else if (phase_ff == swarq_pkg::PHASE_SIGN) begin
               p_phase = swarq_pkg::PHASE_DIGITS;
            end
            if (take_digit) begin
               if (is_digit) begin
                  if (!ovf_ff) begin
                     if (scaled[XW-1:SW] != '0) begin
                        p_ovf = 1'b1;
                     end else begin
                        p_value = scaled[SW-1:0];
                     end
                  end
               end else begin
                  p_phase = swarq_pkg::PHASE_DONE;
               end
            end
         end
      end
   end

   assign tick_limit = (timeout_ticks == '0) ? TW'(1) : timeout_ticks;

   always_comb begin
      logic resend;
      logic clear;
      logic match;
      resend        = 1'b0;
      clear         = 1'b0;
      match         = 1'b0;
      busy_in       = busy_ff;
      seq_in        = seq_ff;
      total_in      = total_ff;
      wait_in       = wait_ff;
      resend_cnt_in = resend_cnt_ff;
      sum_in        = sum_ff;
      action_in     = action_ff;
      aborted_in    = aborted_ff;
      pos_in        = pos_ff;
      prefix_ok_in  = prefix_ok_ff;
      phase_in      = phase_ff;
      neg_in        = neg_ff;
      value_in      = value_ff;
      ovf_in        = ovf_ff;
      if (cmd.commit_start || cmd.commit_item) begin
         action_in  = swarq_pkg::ACTION_NONE;
         aborted_in = 1'b0;
      end
      if (cmd.commit_start) begin
         total_in      = div_quo_ff[SW-1:0];
         wait_in       = '0;
         resend_cnt_in = '0;
         sum_in        = '0;
         clear         = 1'b1;
         if (div_quo_ff[SW-1:0] == '0) begin
            seq_in    = '0;
            busy_in   = 1'b0;
            action_in = swarq_pkg::ACTION_DONE;
         end else begin
            seq_in    = SW'(1);
            busy_in   = 1'b1;
            action_in = swarq_pkg::ACTION_SEND;
         end
      end else if (cmd.commit_item) begin
         case (swarq_pkg::mode_type'(req_mode))
            swarq_pkg::MODE_TICK: begin
               if (!busy_ff) begin
                  clear = 1'b1;
               end else begin
                  wait_in = wait_ff + TW'(1);
                  if (wait_in >= tick_limit) begin
                     resend = 1'b1;
                  end
               end
            end
            swarq_pkg::MODE_BYTE: begin
               if (!busy_ff) begin
                  clear = 1'b1;
               end else begin
                  wait_in      = '0;
                  pos_in       = p_pos;
                  prefix_ok_in = p_prefix_ok;
                  phase_in     = p_phase;
                  neg_in       = p_neg;
                  value_in     = p_value;
                  ovf_in       = p_ovf;
                  if (req_ack_last) begin
                     match = p_prefix_ok && (p_pos >= POS_WIDTH'(swarq_pkg::MIN_ACK_BYTES))
                           && !p_neg && !p_ovf && (p_value == seq_ff);
                     if (match) begin
                        clear         = 1'b1;
                        resend_cnt_in = '0;
                        if (seq_ff >= total_ff) begin
                           busy_in   = 1'b0;
                           action_in = swarq_pkg::ACTION_DONE;
                        end else begin
                           seq_in    = seq_ff + SW'(1);
                           action_in = swarq_pkg::ACTION_SEND;
                        end
                     end else begin
                        resend = 1'b1;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (resend) begin
         action_in  = swarq_pkg::ACTION_RESEND;
         aborted_in = (resend_cnt_ff >= max_resends);
         if (resend_cnt_ff != '1) begin
            resend_cnt_in = resend_cnt_ff + RW'(1);
         end
         if (sum_ff != '1) begin
            sum_in = sum_ff + UW'(1);
         end
         wait_in = '0;
         clear   = 1'b1;
         if (resend_cnt_ff >= max_resends) begin
            busy_in = 1'b0;
         end
      end
      if (clear) begin
         pos_in       = '0;
         prefix_ok_in = 1'b1;
         phase_in     = swarq_pkg::PHASE_SPACE;
         neg_in       = 1'b0;
         value_in     = '0;
         ovf_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         seq_ff        <= '0;
         total_ff      <= '0;
         wait_ff       <= '0;
         resend_cnt_ff <= '0;
         sum_ff        <= '0;
         pos_ff        <= '0;
         prefix_ok_ff  <= 1'b1;
         phase_ff      <= swarq_pkg::PHASE_SPACE;
         neg_ff        <= 1'b0;
         value_ff      <= '0;
         ovf_ff        <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         seq_ff        <= seq_in;
         total_ff      <= total_in;
         wait_ff       <= wait_in;
         resend_cnt_ff <= resend_cnt_in;
         sum_ff        <= sum_in;
         pos_ff        <= pos_in;
         prefix_ok_ff  <= prefix_ok_in;
         phase_ff      <= phase_in;
         neg_ff        <= neg_in;
         value_ff      <= value_in;
         ovf_ff        <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff  <= action_in;
      aborted_ff <= aborted_in;
   end

   // The transfer state only changes when a new result is committed, so it
   // stands directly on the result port.
   assign rsp_action       = action_ff;
   assign rsp_aborted      = aborted_ff;
   assign rsp_packet_seq   = seq_ff;
   assign rsp_packet_total = total_ff;
   assign rsp_resent_total = sum_ff;

endmodule

[rtl/stop_and_wait_arq_sender_unit.sv]
// A tick or ACK byte word gives its result word in the cycle after it is
// accepted; a start word first runs the bit-serial packet count divider (one
// quotient bit per cycle over a 32-bit dividend), then a finish state. Throughput:
// one tick or byte word per cycle unless rsp_stall holds; none while a start runs.
// Reset clears transfer (not action/aborted), parser and handshake state and
// loads the register defaults (payload size 800, timeout 10 ticks, 16 resends).
// ----------------------------------------------------------------------------
// Stop-and-wait sender top level
// Register port, controller and datapath of the ARQ sender control.
// ----------------------------------------------------------------------------
module stop_and_wait_arq_sender_unit #(
   parameter int ACK_MAX_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [30:0] req_file_length,
   input  logic [7:0]  req_ack_byte,
   input  logic        req_ack_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_action,
   output logic        rsp_aborted,
   output logic [30:0] rsp_packet_seq,
   output logic [30:0] rsp_packet_total,
   output logic [31:0] rsp_resent_total,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [swarq_pkg::PAYLOAD_WIDTH-1:0] pkt_bytes_ff, pkt_bytes_in;
   logic [swarq_pkg::TICK_WIDTH-1:0]    timeout_ticks_ff, timeout_ticks_in;
   logic [swarq_pkg::RESEND_WIDTH-1:0]  max_resends_ff, max_resends_in;
   logic                                csr_write;
   swarq_pkg::cmd_type                  cmd;
   swarq_pkg::status_type               status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      pkt_bytes_in     = pkt_bytes_ff;
      timeout_ticks_in = timeout_ticks_ff;
      max_resends_in   = max_resends_ff;
      if (csr_write) begin
         case (paddr[3:2])
            swarq_pkg::CSR_PKT_BYTES:     pkt_bytes_in     = pwdata[15:0];
            swarq_pkg::CSR_TIMEOUT_TICKS: timeout_ticks_in = pwdata[7:0];
            swarq_pkg::CSR_MAX_RESENDS:   max_resends_in   = pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         swarq_pkg::CSR_PKT_BYTES:     prdata = {16'h0000, pkt_bytes_ff};
         swarq_pkg::CSR_TIMEOUT_TICKS: prdata = {24'h000000, timeout_ticks_ff};
         swarq_pkg::CSR_MAX_RESENDS:   prdata = {24'h000000, max_resends_ff};
         default:                      prdata = 32'h00000000;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_bytes_ff     <= swarq_pkg::PAYLOAD_RESET;
         timeout_ticks_ff <= swarq_pkg::TIMEOUT_RESET;
         max_resends_ff   <= swarq_pkg::RESENDS_RESET;
      end else begin
         pkt_bytes_ff     <= pkt_bytes_in;
         timeout_ticks_ff <= timeout_ticks_in;
         max_resends_ff   <= max_resends_in;
      end
   end

   swarq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   swarq_dp #(
      .ACK_MAX_BYTES (ACK_MAX_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_mode         (req_mode),
      .req_file_length  (req_file_length),
      .req_ack_byte     (req_ack_byte),
      .req_ack_last     (req_ack_last),
      .pkt_bytes        (pkt_bytes_ff),
      .timeout_ticks    (timeout_ticks_ff),
      .max_resends      (max_resends_ff),
      .rsp_action       (rsp_action),
      .rsp_aborted      (rsp_aborted),
      .rsp_packet_seq   (rsp_packet_seq),
      .rsp_packet_total (rsp_packet_total),
      .rsp_resent_total (rsp_resent_total)
   );

endmodule
